[rtl/display_inactivity_dimmer_top_macros.svh]
// Assertion macros used by the display dimmer RTL
`ifndef DISPLAY_INACTIVITY_DIMMER_TOP_MACROS_SVH
`define DISPLAY_INACTIVITY_DIMMER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define DID_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("display dimmer check failed");

// Next-cycle implication, disabled during reset
`define DID_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("display dimmer check failed");

`else

`define DID_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define DID_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

[rtl/did_pkg.sv]
// Types and constants for the display inactivity dimmer
package did_pkg;

    localparam int TIME_BITS     = 32;
    localparam int NOW_BITS      = 32;
    localparam int PCT_BITS      = 7;
    localparam int SEC_BITS      = 16;
    localparam int REV_BITS      = 16;
    localparam int MS_PER_SECOND = 1000;
    // 65535 s * 1000 fits in 26 bits
    localparam int MS_BITS       = 26;
    localparam int CMP_BITS      = (TIME_BITS > MS_BITS) ? TIME_BITS : MS_BITS;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 32;

    localparam logic [PCT_BITS-1:0] PCT_MAX = PCT_BITS'(100);

    typedef enum logic [1:0] {
        STAGE_FULL = 2'd0,
        STAGE_DIM  = 2'd1,
        STAGE_OFF  = 2'd2
    } t_stage;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_BATT_BRIGHT = 3'd0,
        CFG_USB_BRIGHT  = 3'd1,
        CFG_DIM_CAP     = 3'd2,
        CFG_DIM_SECS    = 3'd3,
        CFG_OFF_SECS    = 3'd4
    } t_cfg_addr;

    typedef struct packed {
        logic                 started;
        logic                 batt;
        t_stage               stage;
        logic [TIME_BITS-1:0] last;
        logic [PCT_BITS-1:0]  req;
        logic [PCT_BITS-1:0]  app;
        logic                 twf;
        logic [REV_BITS-1:0]  rev;
    } t_dim_state;

    // last member sits in the lowest bits
    typedef struct packed {
        logic [REV_BITS-1:0] count;
        logic                on_batt;
        logic                twf;
        logic [PCT_BITS-1:0] pct;
        t_stage              stage;
        logic                woke;
    } t_result;

endpackage

[rtl/display_inactivity_dimmer_top.sv]
// Display inactivity dimmer: battery/USB backlight staging per update tick
//
// Takes one update word per clock cycle, back to back, while the output side
// is not stalled. A word passes an input register, then the update logic
// writes the dimmer state and the result register together. The state
// feedback loop closes through the state register alone, which sets the
// one-word-per-cycle rate. Millisecond thresholds are computed when the
// second registers are written, keeping the tick path to a subtract and two
// compares. Write configuration only while no word is in flight.
`include "display_inactivity_dimmer_top_macros.svh"

module display_inactivity_dimmer_top import did_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config write port
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    // update words
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // now_ms[31:0], pmic_available[32], battery_present[33], vbus_present[34],
    // vbus_ok[35], user_activity[36], zero fill [39:37]
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // result words
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // woke_from_activity[0], display_stage[2:1], backlight_percent[9:3],
    // touch_wake_only[10], on_battery[11], change_count[27:12], zero fill [31:28]
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    // configuration
    logic [PCT_BITS-1:0] r_batt_bright;
    logic [PCT_BITS-1:0] r_usb_bright;
    logic [PCT_BITS-1:0] r_dim_cap;
    logic [MS_BITS-1:0]  r_dim_ms;
    logic [MS_BITS-1:0]  r_off_ms;

    // pipeline
    logic                    r_in_valid;
    logic [IN_DATA_BITS-1:0] r_in_data;
    logic                    r_out_valid;
    t_result                 r_out;
    t_dim_state              r_st;

    logic       w_adv;
    logic       w_fire;
    t_dim_state n_st;
    t_result    n_out;

    logic [PCT_BITS-1:0] w_wdata_pct;
    logic [PCT_BITS-1:0] w_sat_pct;
    logic [MS_BITS-1:0]  w_wdata_ms;

    // ---------------- update helpers ----------------
    function automatic logic [NOW_BITS-1:0] s_axis_data_now(logic [IN_DATA_BITS-1:0] d);
        return d[NOW_BITS-1:0];
    endfunction

    function automatic t_dim_state f_bump(t_dim_state s);
        s.rev = s.rev + REV_BITS'(1);
        return s;
    endfunction

    function automatic t_dim_state f_drive(t_dim_state s, logic [PCT_BITS-1:0] pct,
                                           logic force_wr);
        if (force_wr || (pct != s.req)) begin
            s.req = pct;
            if (s.app != pct) begin
                s.app = pct;
                s = f_bump(s);
            end
        end
        return s;
    endfunction

    function automatic t_dim_state f_full(t_dim_state s, logic force_wr,
                                          logic [PCT_BITS-1:0] bb, logic [PCT_BITS-1:0] ub);
        t_stage prev_stage;
        prev_stage = s.stage;
        s.stage    = STAGE_FULL;
        s          = f_drive(s, s.batt ? bb : ub, force_wr);
        if (prev_stage != STAGE_FULL) begin
            s = f_bump(s);
        end
        return s;
    endfunction

    function automatic t_dim_state f_wake(t_dim_state s, logic [TIME_BITS-1:0] now,
                                          logic [PCT_BITS-1:0] bb, logic [PCT_BITS-1:0] ub);
        s.last = now;
        s.twf  = 1'b0;
        return f_full(s, 1'b1, bb, ub);
    endfunction

    function automatic t_dim_state f_dim(t_dim_state s, logic [PCT_BITS-1:0] lvl);
        if (s.stage == STAGE_DIM) begin
            s = f_drive(s, lvl, 1'b0);
        end else begin
            s.stage = STAGE_DIM;
            s       = f_drive(s, lvl, 1'b1);
            s       = f_bump(s);
        end
        return s;
    endfunction

    function automatic t_dim_state f_off(t_dim_state s);
        if (s.stage != STAGE_OFF) begin
            s.stage = STAGE_OFF;
            s       = f_drive(s, '0, 1'b1);
            s.twf   = 1'b1;
            s       = f_bump(s);
        end
        return s;
    endfunction

    // ---------------- configuration ----------------
    assign w_wdata_pct = i_cfg_wdata[PCT_BITS-1:0];
    assign w_sat_pct   = (w_wdata_pct > PCT_MAX) ? PCT_MAX : w_wdata_pct;
    assign w_wdata_ms  = MS_BITS'(i_cfg_wdata) * MS_BITS'(MS_PER_SECOND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batt_bright <= PCT_MAX;
            r_usb_bright  <= PCT_MAX;
            r_dim_cap     <= PCT_BITS'(15);
            r_dim_ms      <= MS_BITS'(30 * MS_PER_SECOND);
            r_off_ms      <= MS_BITS'(60 * MS_PER_SECOND);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_BATT_BRIGHT: r_batt_bright <= w_sat_pct;
                CFG_USB_BRIGHT:  r_usb_bright  <= w_sat_pct;
                CFG_DIM_CAP:     r_dim_cap     <= w_sat_pct;
                CFG_DIM_SECS:    r_dim_ms      <= w_wdata_ms;
                CFG_OFF_SECS:    r_off_ms      <= w_wdata_ms;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_BITS'(r_out);

    // ---------------- tick update ----------------
    always_comb begin
        logic [TIME_BITS-1:0] now;
        logic                 batt;
        logic                 act;
        logic                 woke;
        logic [TIME_BITS-1:0] idle;
        logic [PCT_BITS-1:0]  dim_lvl;
        t_dim_state           s;

        now     = TIME_BITS'(s_axis_data_now(r_in_data));
        batt    = r_in_data[32] && r_in_data[33] && !r_in_data[34] && !r_in_data[35];
        act     = r_in_data[36];
        woke    = 1'b0;
        idle    = '0;
        dim_lvl = (r_batt_bright < r_dim_cap) ? r_batt_bright : r_dim_cap;
        s       = r_st;

        // first tick sets everything up
        if (!s.started) begin
            s.batt    = batt;
            s.last    = now;
            s.started = 1'b1;
            s.stage   = STAGE_FULL;
            s.app     = '0;
            s.rev     = '0;
            s.twf     = 1'b0;
            s         = f_full(s, 1'b1, r_batt_bright, r_usb_bright);
        end

        // supply change: both directions restore full brightness
        if (batt != s.batt) begin
            s.batt = batt;
            s      = f_wake(s, now, r_batt_bright, r_usb_bright);
            s      = f_bump(s);
        end

        if (!s.batt) begin
            if (s.stage != STAGE_FULL) begin
                s = f_wake(s, now, r_batt_bright, r_usb_bright);
            end
            s = f_full(s, 1'b0, r_batt_bright, r_usb_bright);
        end else begin
            if (act) begin
                s.last = now;
                if (s.stage == STAGE_OFF) begin
                    woke = 1'b1;
                    s    = f_wake(s, now, r_batt_bright, r_usb_bright);
                end else if (s.stage == STAGE_DIM) begin
                    s = f_full(s, 1'b1, r_batt_bright, r_usb_bright);
                end
            end
            if (s.stage != STAGE_OFF) begin
                idle = now - s.last;
                if ((r_off_ms != '0) && (CMP_BITS'(idle) >= CMP_BITS'(r_off_ms))) begin
                    s = f_off(s);
                end else if (CMP_BITS'(idle) >= CMP_BITS'(r_dim_ms)) begin
                    s = f_dim(s, dim_lvl);
                end else begin
                    s = f_full(s, 1'b0, r_batt_bright, r_usb_bright);
                end
            end
        end

        n_st          = s;
        n_out.woke    = woke;
        n_out.stage   = s.stage;
        n_out.pct     = s.app;
        n_out.twf     = s.twf;
        n_out.on_batt = s.batt;
        n_out.count   = s.rev;
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st.started <= 1'b0;
            r_st.batt    <= 1'b0;
            r_st.stage   <= STAGE_FULL;
            r_st.last    <= '0;
            r_st.req     <= '0;
            r_st.app     <= '0;
            r_st.twf     <= 1'b0;
            r_st.rev     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_st.started <= n_st.started;
                r_st.batt    <= n_st.batt;
                r_st.stage   <= n_st.stage;
                r_st.last    <= n_st.last;
                r_st.req     <= n_st.req;
                r_st.app     <= n_st.app;
                r_st.twf     <= n_st.twf;
                r_st.rev     <= n_st.rev;
            end
        end
    end

    // payload: qualified by the valid flags, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    // ---------------- checks ----------------
    `DID_ASSERT_IMPLY(a_off_is_blank, i_clk, i_rst_n,
        r_out_valid && (r_out.stage == STAGE_OFF), (r_out.pct == '0) && r_out.twf)
    `DID_ASSERT_IMPLY(a_usb_full, i_clk, i_rst_n,
        r_out_valid && !r_out.on_batt, (r_out.stage == STAGE_FULL) && !r_out.twf)
    `DID_ASSERT_IMPLY(a_wake_lit, i_clk, i_rst_n,
        r_out_valid && r_out.woke, r_out.on_batt && (r_out.stage != STAGE_OFF))
    `DID_ASSERT_NEXT(a_state_moves_with_result, i_clk, i_rst_n,
        !w_fire && r_st.started, $stable(r_st.rev) && $stable(r_st.stage))

endmodule

[test/tb_display_inactivity_dimmer_top.sv]
// Self-checking stream bench for the display inactivity dimmer top level
module tb_display_inactivity_dimmer_top;
    import did_pkg::*;

    localparam int STALL_CYCLES     = 300;
    localparam int TICKS_PER_PHASE  = 200;
    localparam int PHASES           = 8;
    localparam int STALL_PHASE      = 4;
    localparam int QUIET_PHASE      = 5;
    // supply bits from the low end: pmic_available, battery_present, vbus_present, vbus_ok
    localparam logic [3:0] SUPPLY_BATTERY = 4'b0011;
    localparam logic [TIME_BITS-1:0] NEAR_WRAP_MS = 32'hFFFF_F000;

    class dimmer_scoreboard;
        logic [PCT_BITS-1:0]  batt_pct = PCT_BITS'(100);
        logic [PCT_BITS-1:0]  usb_pct  = PCT_BITS'(100);
        logic [PCT_BITS-1:0]  dim_cap  = PCT_BITS'(15);
        logic [SEC_BITS-1:0]  dim_s    = SEC_BITS'(30);
        logic [SEC_BITS-1:0]  off_s    = SEC_BITS'(60);

        bit                   started    = 1'b0;
        bit                   batt_mode  = 1'b0;
        t_stage               stage      = STAGE_FULL;
        logic [TIME_BITS-1:0] last_ms    = '0;
        logic [PCT_BITS-1:0]  req_pct    = '0;
        logic [PCT_BITS-1:0]  app_pct    = '0;
        bit                   touch_only = 1'b0;
        logic [REV_BITS-1:0]  rev        = '0;

        t_result status_q[$];
        int ticks = 0, checked = 0, fails = 0;
        int dims = 0, blanks = 0, wakes = 0, switches = 0, settings = 1;

        function logic [PCT_BITS-1:0] clamp_pct(logic [CFG_DATA_BITS-1:0] val);
            return (val[PCT_BITS-1:0] > PCT_MAX) ? PCT_MAX : val[PCT_BITS-1:0];
        endfunction

        function void write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_BATT_BRIGHT: batt_pct = clamp_pct(val);
                CFG_USB_BRIGHT:  usb_pct  = clamp_pct(val);
                CFG_DIM_CAP:     dim_cap  = clamp_pct(val);
                CFG_DIM_SECS:    dim_s    = val;
                CFG_OFF_SECS:    off_s    = val;
                default: ;
            endcase
        endfunction

        function void bump();
            rev = rev + 1'b1;
        endfunction

        function void set_backlight(logic [PCT_BITS-1:0] pct, bit force_it);
            logic [PCT_BITS-1:0] prior;
            if (!force_it && pct == req_pct) return;
            req_pct = pct;
            prior   = app_pct;
            app_pct = pct;
            if (app_pct != prior) bump();
        endfunction

        function void to_full(bit force_it);
            t_stage prior;
            prior = stage;
            stage = STAGE_FULL;
            set_backlight(batt_mode ? batt_pct : usb_pct, force_it);
            if (prior != stage) bump();
        endfunction

        function void to_dim();
            logic [PCT_BITS-1:0] level;
            level = (batt_pct < dim_cap) ? batt_pct : dim_cap;
            if (stage == STAGE_DIM) begin
                set_backlight(level, 1'b0);
            end else begin
                stage = STAGE_DIM;
                set_backlight(level, 1'b1);
                bump();
                dims++;
            end
        endfunction

        function void to_off();
            if (stage != STAGE_OFF) begin
                stage = STAGE_OFF;
                set_backlight('0, 1'b1);
                touch_only = 1'b1;
                bump();
                blanks++;
            end
        endfunction

        function bit wake(logic [TIME_BITS-1:0] now);
            bit was_off;
            was_off    = (stage == STAGE_OFF);
            last_ms    = now;
            touch_only = 1'b0;
            to_full(1'b1);
            return was_off;
        endfunction

        // Predict the status word for one accepted tick and queue it
        function void note_tick(logic [IN_DATA_BITS-1:0] word);
            logic [TIME_BITS-1:0] now, idle, off_ms, dim_ms;
            bit on_batt, act;
            t_result r;
            now     = word[31:0];
            on_batt = word[32] && word[33] && !word[34] && !word[35];
            act     = word[36];
            r.woke  = 1'b0;
            ticks++;
            if (!started) begin
                batt_mode  = on_batt;
                last_ms    = now;
                started    = 1'b1;
                stage      = STAGE_FULL;
                app_pct    = '0;
                rev        = '0;
                touch_only = 1'b0;
                to_full(1'b1);
            end
            if (on_batt != batt_mode) begin
                batt_mode = on_batt;
                last_ms   = now;
                switches++;
                if (!on_batt) begin
                    void'(wake(now));
                end else begin
                    touch_only = 1'b0;
                    to_full(1'b1);
                end
                bump();
            end
            if (!batt_mode) begin
                if (stage != STAGE_FULL) void'(wake(now));
                to_full(1'b0);
            end else begin
                if (act) begin
                    last_ms = now;
                    if (stage == STAGE_OFF) r.woke = wake(now);
                    else if (stage == STAGE_DIM) to_full(1'b1);
                end
                if (stage != STAGE_OFF) begin
                    idle   = now - last_ms;
                    off_ms = TIME_BITS'(off_s) * MS_PER_SECOND;
                    dim_ms = TIME_BITS'(dim_s) * MS_PER_SECOND;
                    if (off_s != 0 && idle >= off_ms) to_off();
                    else if (idle >= dim_ms) to_dim();
                    else to_full(1'b0);
                end
            end
            if (r.woke) wakes++;
            r.stage   = stage;
            r.pct     = app_pct;
            r.twf     = touch_only;
            r.on_batt = batt_mode;
            r.count   = rev;
            status_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_BITS-1:0] word);
            t_result want;
            if (status_q.size() == 0) begin
                $error("status word %h arrived with nothing pending", word);
                fails++;
                return;
            end
            want = status_q.pop_front();
            checked++;
            compare_field("woke_from_activity", want.woke,    word[0]);
            compare_field("display_stage",      want.stage,   word[2:1]);
            compare_field("backlight_percent",  want.pct,     word[9:3]);
            compare_field("touch_wake_only",    want.twf,     word[10]);
            compare_field("on_battery",         want.on_batt, word[11]);
            compare_field("change_count",       want.count,   word[27:12]);
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    dimmer_scoreboard sb = new;
    int                   sent          = 0;
    bit                   stall_request = 1'b0;
    bit                   quiet         = 1'b0;
    logic [TIME_BITS-1:0] tick_ms       = '0;

    display_inactivity_dimmer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Sample both handshakes and register writes on the edge that takes them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en) sb.write_reg(i_cfg_addr, i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready) sb.note_tick(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 11);
        end
    end

    function automatic logic [IN_DATA_BITS-1:0] tick_word(logic [TIME_BITS-1:0] now,
                                                        logic [3:0] supply, logic act);
        return {3'b000, act, supply, now};
    endfunction

    task automatic send_tick(input logic [IN_DATA_BITS-1:0] word);
        if (!quiet && $urandom_range(0, 99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (sb.ticks != sent || sb.status_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic program_phase(input int phase, output int unsigned span_ms);
        logic [CFG_DATA_BITS-1:0] bb, ub, cap, ds, os;
        case (phase)
            0: begin
                bb = 100; ub = 0; cap = 100; ds = 0; os = 0;
            end
            1: begin
                bb = 0; ub = 100; cap = 0; ds = 1; os = 2;
            end
            2: begin
                bb = 16'hFFFF; ub = 16'h00C8; cap = 127; ds = 16'hFFFF; os = 16'hFFFF;
            end
            3: begin
                // blank before dim; usb value with only upper bits set
                bb = 55; ub = 16'h0180; cap = 100; ds = 5; os = 3;
            end
            default: begin
                bb  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 100));
                ub  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 100));
                cap = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 100));
                ds  = 16'($urandom_range(0, 6));
                os  = 16'($urandom_range(0, 10));
            end
        endcase
        write_reg(CFG_BATT_BRIGHT, bb);
        write_reg(CFG_USB_BRIGHT, ub);
        write_reg(CFG_DIM_CAP, cap);
        write_reg(CFG_DIM_SECS, ds);
        write_reg(CFG_OFF_SECS, os);
        // unmapped index: must leave every register alone
        write_reg(CFG_OFF_SECS + 3'($urandom_range(1, 3)), 16'($urandom));
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        sb.settings++;
        span_ms = ((ds > os) ? ds : os) * MS_PER_SECOND / 2 + 200;
    endtask

    task automatic run_ticks(input int count, input int unsigned span_ms, input bit with_stall);
        int unsigned pick, thr;
        logic [3:0]  supply;
        logic        act;
        for (int n = 0; n < count; n++) begin
            if (with_stall && n == 40) stall_request = 1'b1;
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                tick_ms = $urandom;
            end else if (pick <= 3) begin
                // land right around a threshold
                thr = $urandom_range(0, 1) ? sb.dim_s : sb.off_s;
                tick_ms = sb.last_ms + thr * MS_PER_SECOND - 1 + $urandom_range(0, 2);
            end else if (pick > 4) begin
                tick_ms = tick_ms + $urandom_range(0, span_ms);
            end
            supply = ($urandom_range(0, 99) < 90) ? SUPPLY_BATTERY : 4'($urandom);
            act    = ($urandom_range(0, 99) < 8);
            send_tick(tick_word(tick_ms, supply, act));
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic run_directed();
        send_tick(tick_word(NEAR_WRAP_MS, SUPPLY_BATTERY, 1'b0));
        send_tick(tick_word(32'hFFFF_FFFF, SUPPLY_BATTERY, 1'b0));
        send_tick(tick_word(NEAR_WRAP_MS + 29_999, SUPPLY_BATTERY, 1'b0));
        send_tick(tick_word(NEAR_WRAP_MS + 30_000, SUPPLY_BATTERY, 1'b0));
        send_tick(tick_word(NEAR_WRAP_MS + 45_000, SUPPLY_BATTERY, 1'b1));
        send_tick(tick_word(NEAR_WRAP_MS + 104_999, SUPPLY_BATTERY, 1'b0));
        send_tick(tick_word(NEAR_WRAP_MS + 105_000, SUPPLY_BATTERY, 1'b0));
        send_tick(tick_word(NEAR_WRAP_MS + 115_000, SUPPLY_BATTERY, 1'b0));
        send_tick(tick_word(NEAR_WRAP_MS + 116_000, SUPPLY_BATTERY, 1'b1));
        send_tick(tick_word(NEAR_WRAP_MS + 116_000, 4'b0111, 1'b0));
        send_tick(tick_word(NEAR_WRAP_MS + 117_000, 4'b1011, 1'b1));
        send_tick(tick_word(NEAR_WRAP_MS + 118_000, 4'b0010, 1'b0));
        send_tick(tick_word(NEAR_WRAP_MS + 119_000, 4'b0001, 1'b0));
        send_tick(tick_word(32'hFFFF_FFFF, 4'b1111, 1'b1));
        send_tick(tick_word(32'd0, SUPPLY_BATTERY, 1'b0));
        send_tick(tick_word(32'd61_000, SUPPLY_BATTERY, 1'b0));
        send_tick(tick_word(32'd62_000, 4'b1011, 1'b0));
        send_tick(tick_word(32'd62_000, SUPPLY_BATTERY, 1'b0));
        send_tick(tick_word(32'd92_000, SUPPLY_BATTERY, 1'b0));
        send_tick(tick_word(32'hFFFF_FFFF, SUPPLY_BATTERY, 1'b1));
        send_tick(tick_word(32'd0, SUPPLY_BATTERY, 1'b0));
        s_axis_tvalid <= 1'b0;
        tick_ms = '0;
    endtask

    initial begin
        int unsigned span_ms;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = CFG_BATT_BRIGHT;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            program_phase(phase, span_ms);
            quiet = (phase == QUIET_PHASE);
            run_ticks(TICKS_PER_PHASE, span_ms, phase == STALL_PHASE);
        end
        quiet = 1'b0;
        wait_idle();
        repeat (4) @(posedge i_clk);

        $display("Checked %0d status words from %0d ticks over %0d register settings",
                 sb.checked, sb.ticks, sb.settings);
        $display("Saw %0d dims, %0d blanks, %0d wakes from off, %0d supply switches",
                 sb.dims, sb.blanks, sb.wakes, sb.switches);
        if (sb.fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(12 * 200_000);
        $error("run did not finish in time");
        $display("Regression FAIL");
        $finish;
    end

endmodule
